[hdl/vfp_pkg.sv]
// ----------------------------------------------------------------------------
// vfp_pkg
// Shared widths, constants, types and helpers of the FOV projection unit.
// ----------------------------------------------------------------------------
`default_nettype none

package vfp_pkg;

  localparam int FRAC_BITS     = 16;
  localparam int CORDIC_STAGES = 20;
  localparam int ANG_BITS      = 30;

  localparam int FOV_W  = 24;
  localparam int DIM_W  = 12;
  localparam int TIME_W = 32;
  localparam int OUT_W  = 25;
  localparam int DIV_W  = 24;

  localparam int XY_W = 48;                  // CORDIC x/y, holds w*cos growth
  localparam int Z_W  = 40;                  // angles, Q30 degrees
  localparam int S_W  = Z_W + 2;             // sums before rounding
  localparam int P_W  = ANG_BITS + 2;        // sine pulse, Q30
  localparam int CX_W = ANG_BITS + 3;        // cos/sin after rotation
  localparam int SH_W = $clog2(CORDIC_STAGES);
  localparam int Q_SH = ANG_BITS - FRAC_BITS;
  localparam int Q_W  = OUT_W + FRAC_BITS;   // dividend bits

  localparam longint DEG_ONE = 64'sd1 <<< ANG_BITS;
  localparam longint DEG90   = 90 * DEG_ONE;
  localparam longint DEG180  = 180 * DEG_ONE;
  localparam longint DEG270  = 270 * DEG_ONE;
  localparam longint DEG360  = 360 * DEG_ONE;
  localparam longint GAIN_Q30 = 64'sd652032874;
  localparam longint HALF_LSB = 64'sd1 <<< (Q_SH - 1);
  localparam longint OUT_MAX  = (64'sd1 <<< (OUT_W - 1)) - 1;
  localparam longint OUT_MIN  = -(64'sd1 <<< (OUT_W - 1));

  localparam logic [FOV_W-1:0] FOV_MAX = FOV_W'(180 << FRAC_BITS);
  localparam logic [DIV_W-1:0] DIV_RESET = DIV_W'(5242880);

  // pulse phase: floor(t mod 2500) then scaled to Q30 degrees
  localparam logic [32:0] PH_OFFSET = 33'd2147500000;  // multiple of 2500
  localparam logic [31:0] PH_M1     = 32'd3518437209;  // 2^41 / 625, rounded up
  localparam int          PH_S1     = 41;
  localparam logic [23:0] PH_Q      = 24'd8589934;     // 2^30 div 125
  localparam logic [21:0] PH_R      = 22'd74;          // 2^30 mod 125
  localparam logic [22:0] PH_M2     = 23'd4294968;     // 2^29 / 125, rounded up
  localparam int          PH_S2     = 29;

  localparam logic [0:0] REG_SENS_DIV = 1'b0;

  // pipeline stage numbers
  localparam int NS      = CORDIC_STAGES;
  localparam int ST_ROT  = 6;
  localparam int ST_MUL  = ST_ROT + NS + 1;
  localparam int ST_FIN  = ST_MUL + NS + 1;
  localparam int ST_END  = ST_FIN + Q_W + 1;

  typedef struct packed {
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic signed [Z_W-1:0]  z;
  } cordic_t;

  typedef struct packed {
    logic [DIV_W-1:0] rem;
    logic [Q_W-1:0]   num;
    logic [Q_W-1:0]   q;
  } div_t;

  typedef struct packed {
    logic [FOV_W-1:0]        fx;
    logic [DIM_W-1:0]        w;
    logic [DIM_W-1:0]        h;
    logic                    hit1;
    logic                    hit2;
    logic                    fy_zero;
    logic                    fy_full;
    logic                    base90;
    logic signed [P_W-1:0]   p;
    logic signed [OUT_W-1:0] fxo;
    logic signed [OUT_W-1:0] fyo;
    logic                    neg;
  } side_t;

  // shift-and-subtract long division, only used for table constants
  function automatic longint unsigned udiv64(input longint unsigned n,
                                             input longint unsigned d);
    longint unsigned q;
    longint unsigned r;
    q = 0;
    r = 0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[62:0], n[b]};
      if (r >= d) begin
        r    = r - d;
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // arctan(2^-i) in Q30 degrees, series evaluated at elaboration
  function automatic longint atan_deg(input int unsigned i);
    longint unsigned p;
    longint unsigned sum;
    longint unsigned t;
    longint unsigned res;
    int unsigned     sh;
    if (i == 0) return 45 * DEG_ONE;
    sum = 0;
    p   = 64'd1 << (62 - i);
    sh  = 2 * i;
    for (int k = 0; k < 64; k++) begin
      if (p != 0) begin
        t = udiv64(p, 64'(2 * k + 1));
        if ((k % 2) != 0) sum = sum - t;
        else sum = sum + t;
        p = (sh < 64) ? (p >> sh) : 64'd0;
      end
    end
    res = (((sum >> 28) * 64'd961263669) + (64'd1 << 27)) >> 28;
    return longint'(res);
  endfunction

  function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [S_W-1:0] v);
    if (v > S_W'(OUT_MAX)) return OUT_W'(OUT_MAX);
    if (v < S_W'(OUT_MIN)) return OUT_W'(OUT_MIN);
    return OUT_W'(v);
  endfunction

endpackage

`default_nettype wire

[hdl/vfp_phase.sv]
// ----------------------------------------------------------------------------
// vfp_phase
// Pulse phase: time modulo 2500 ms, scaled to Q30 degrees and folded to +-90.
// ----------------------------------------------------------------------------
`default_nettype none

module vfp_phase import vfp_pkg::*; (
  input  logic                     clk,
  input  logic                     en,
  input  logic signed [TIME_W-1:0] time_ms,
  output logic signed [Z_W-1:0]    ang
);

  logic [32:0]        u_r;
  logic [62:0]        prod1_r;
  logic [30:0]        v2_r;
  logic [1:0]         lo2_r;
  logic [15:0]        m3_r;
  logic [39:0]        mq4_r;
  logic [21:0]        x4_r;
  logic [44:0]        prod5_r;
  logic [39:0]        mq5_r;
  logic [39:0]        angu6_r;
  logic signed [Z_W-1:0] ang_r;

  logic [21:0]        q1;
  logic [9:0]         r1;
  logic [11:0]        ph;
  logic [15:0]        m3_nxt;
  logic [15:0]        q2;
  logic signed [40:0] a_s;
  logic signed [40:0] f_s;

  always_comb begin
    // v mod 625 by reciprocal, exact for 31-bit v
    q1     = prod1_r[62:PH_S1];
    r1     = 10'(v2_r - (31'(q1) * 31'd625));
    ph     = {r1, lo2_r};
    m3_nxt = 16'(ph) * 16'd18;
    q2     = prod5_r[44:PH_S2];
    a_s    = $signed({1'b0, angu6_r});
    if (a_s > 41'(DEG90) && a_s <= 41'(DEG270)) begin
      f_s = 41'(DEG180) - a_s;
    end else if (a_s > 41'(DEG270)) begin
      f_s = a_s - 41'(DEG360);
    end else begin
      f_s = a_s;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      u_r     <= {time_ms[TIME_W-1], time_ms} + PH_OFFSET;
      prod1_r <= 63'(u_r[32:2]) * 63'(PH_M1);
      v2_r    <= u_r[32:2];
      lo2_r   <= u_r[1:0];
      m3_r    <= m3_nxt;
      mq4_r   <= 40'(m3_r) * 40'(PH_Q);
      x4_r    <= 22'(m3_r) * PH_R + 22'd62;
      prod5_r <= 45'(x4_r) * 45'(PH_M2);
      mq5_r   <= mq4_r;
      angu6_r <= mq5_r + 40'(q2);
      ang_r   <= Z_W'(f_s);
    end
  end

  assign ang = ang_r;

endmodule

`default_nettype wire

[hdl/vfp_cordic_cell.sv]
// ----------------------------------------------------------------------------
// vfp_cordic_cell
// One CORDIC micro-rotation, rotation or vectoring mode, registered.
// ----------------------------------------------------------------------------
`default_nettype none

module vfp_cordic_cell import vfp_pkg::*; (
  input  logic                  clk,
  input  logic                  en,
  input  logic                  vec_mode,
  input  logic [SH_W-1:0]       shift,
  input  logic signed [Z_W-1:0] atan_i,
  input  cordic_t               d_i,
  output cordic_t               d_o
);

  cordic_t                d_r;
  cordic_t                d_nxt;
  logic signed [XY_W-1:0] dx;
  logic signed [XY_W-1:0] dy;
  logic                   sgn_pos;

  always_comb begin
    dx = $signed(d_i.y) >>> shift;
    dy = $signed(d_i.x) >>> shift;
    // rotation steers on z, vectoring drives y towards zero
    sgn_pos = vec_mode ? d_i.y[XY_W-1] : ~d_i.z[Z_W-1];
    if (sgn_pos) begin
      d_nxt.x = $signed(d_i.x) - dx;
      d_nxt.y = $signed(d_i.y) + dy;
      d_nxt.z = $signed(d_i.z) - atan_i;
    end else begin
      d_nxt.x = $signed(d_i.x) + dx;
      d_nxt.y = $signed(d_i.y) - dy;
      d_nxt.z = $signed(d_i.z) + atan_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_r <= d_nxt;
    end
  end

  assign d_o = d_r;

endmodule

`default_nettype wire

[hdl/vfp_div_cell.sv]
// ----------------------------------------------------------------------------
// vfp_div_cell
// One restoring-division step: one quotient bit per cell, registered.
// ----------------------------------------------------------------------------
`default_nettype none

module vfp_div_cell import vfp_pkg::*; (
  input  logic             clk,
  input  logic             en,
  input  logic [DIV_W-1:0] divisor,
  input  div_t             d_i,
  output div_t             d_o
);

  div_t           d_r;
  div_t           d_nxt;
  logic [DIV_W:0] r2;
  logic           ge;

  always_comb begin
    r2        = {d_i.rem, d_i.num[Q_W-1]};
    ge        = r2 >= {1'b0, divisor};
    d_nxt.rem = ge ? DIV_W'(r2 - {1'b0, divisor}) : DIV_W'(r2);
    d_nxt.num = {d_i.num[Q_W-2:0], 1'b0};
    d_nxt.q   = {d_i.q[Q_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_r <= d_nxt;
    end
  end

  assign d_o = d_r;

endmodule

`default_nettype wire

[hdl/view_fov_projection_unit.sv]
// ----------------------------------------------------------------------------
// view_fov_projection_unit
// Horizontal to vertical field-of-view conversion with pulse and sensitivity.
// ----------------------------------------------------------------------------
// Takes one item per clock unless stalled. The pipeline is a chain of cells:
// the pulse phase unit (7 stages), two 20-cell CORDIC rotation chains in
// parallel (tan of half FOV and the sine pulse), a multiply stage, a 20-cell
// CORDIC vectoring chain for the angle, a rounding stage and a 41-cell
// restoring divider for the sensitivity. The pipeline only stalls when the
// output register and its skid stage are both full. The divisor register
// should be written only while the block is idle.
`default_nettype none

module view_fov_projection_unit import vfp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  // tdata: fov_horizontal, view_width, view_height, time_ms
  input  logic [79:0] in_tdata,
  // tuser: first_query_hit, second_query_hit
  input  logic [1:0]  in_tuser,
  input  logic        in_tvalid,
  output logic        in_tready,
  // tdata: fov_x_out, fov_y_out, sensitivity, zero padding
  output logic [79:0] out_tdata,
  // tuser: draw_flag, first_hit
  output logic [1:0]  out_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  logic             en;
  logic [DIV_W-1:0] div_r;

  side_t            side_r   [0:ST_END];
  side_t            side_nxt [0:ST_END];
  logic [ST_END:0]  vld_r;

  logic signed [Z_W-1:0] ph_ang;
  cordic_t               tan_d [0:NS];
  cordic_t               sin_d [0:NS];
  cordic_t               vec_d [0:NS];
  cordic_t               vec0_nxt;
  div_t                  dv_d  [0:Q_W];
  logic [Q_W-1:0]        mag_r;
  logic [Q_W-1:0]        mag_nxt;
  logic signed [OUT_W-1:0] sens_r;
  logic signed [OUT_W-1:0] sens_nxt;

  logic [79:0] res_data;
  logic [1:0]  res_user;
  logic [79:0] out_data_r, out_data_nxt, skid_data_r, skid_data_nxt;
  logic [1:0]  out_user_r, out_user_nxt, skid_user_r, skid_user_nxt;
  logic        out_valid_r, out_valid_nxt, skid_valid_r, skid_valid_nxt;

  // ---- configuration ----
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == REG_SENS_DIV) ? 32'(div_r) : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_r <= DIV_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                 cfg_paddr[2] == REG_SENS_DIV) begin
      div_r <= cfg_pwdata[DIV_W-1:0];
    end
  end

  // ---- flow control ----
  assign en        = ~skid_valid_r;
  assign in_tready = en;

  // ---- pulse phase ----
  vfp_phase u_phase (
    .clk     (clk),
    .en      (en),
    .time_ms ($signed(in_tdata[79:48])),
    .ang     (ph_ang)
  );

  // ---- rotation chains ----
  always_comb begin
    tan_d[0].x = XY_W'(DEG_ONE);
    tan_d[0].y = '0;
    tan_d[0].z = Z_W'({side_r[ST_ROT].fx, {(Q_SH - 1){1'b0}}});
    sin_d[0].x = XY_W'(GAIN_Q30);
    sin_d[0].y = '0;
    sin_d[0].z = ph_ang;
  end

  for (genvar j = 0; j < NS; j++) begin : g_rot
    localparam longint ATAN_J = atan_deg(j);
    vfp_cordic_cell u_tan (
      .clk(clk), .en(en), .vec_mode(1'b0), .shift(SH_W'(j)),
      .atan_i(Z_W'(ATAN_J)), .d_i(tan_d[j]), .d_o(tan_d[j+1])
    );
    vfp_cordic_cell u_sin (
      .clk(clk), .en(en), .vec_mode(1'b0), .shift(SH_W'(j)),
      .atan_i(Z_W'(ATAN_J)), .d_i(sin_d[j]), .d_o(sin_d[j+1])
    );
    vfp_cordic_cell u_vec (
      .clk(clk), .en(en), .vec_mode(1'b1), .shift(SH_W'(j)),
      .atan_i(Z_W'(ATAN_J)), .d_i(vec_d[j]), .d_o(vec_d[j+1])
    );
  end

  // ---- scale by view size, quadrant fix ----
  logic signed [DIM_W:0]        wn, hn;
  logic signed [CX_W-1:0]       cxn, cyn;
  logic signed [DIM_W+CX_W:0]   px_p, py_p;
  logic signed [XY_W-1:0]       px, py;
  logic                         swap;
  logic signed [P_W-1:0]        p_val;

  always_comb begin
    wn   = $signed({1'b0, side_r[ST_MUL-1].w});
    hn   = $signed({1'b0, side_r[ST_MUL-1].h});
    cxn  = tan_d[NS].x[CX_W-1:0];
    cyn  = tan_d[NS].y[CX_W-1:0];
    px_p = wn * cxn;
    py_p = hn * cyn;
    px   = XY_W'(px_p);
    py   = XY_W'(py_p);
    swap = px[XY_W-1];
    // cos went negative: rotate the vector back by 90 degrees
    vec0_nxt.x = swap ? py : px;
    vec0_nxt.y = swap ? -px : py;
    vec0_nxt.z = '0;
    p_val = side_r[ST_MUL-1].hit1 ? P_W'($signed(sin_d[NS].y)) : '0;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      vec_d[0] <= vec0_nxt;
    end
  end

  // ---- rounding to Q8.16 ----
  side_t                   sf;
  logic signed [S_W-1:0]   yq, xs, ys;
  logic signed [OUT_W-1:0] fxo_c, fyo_c;
  logic [OUT_W-1:0]        absv;

  always_comb begin
    sf = side_r[ST_FIN-1];
    yq = S_W'($signed(vec_d[NS].z)) + (sf.base90 ? S_W'(DEG90) : S_W'(0));
    yq = yq <<< 1;
    if (yq < 0) yq = '0;
    else if (yq > S_W'(DEG180)) yq = S_W'(DEG180);
    if (sf.fy_zero) yq = '0;
    else if (sf.fy_full) yq = S_W'(DEG180);
    xs    = $signed(S_W'({sf.fx, {Q_SH{1'b0}}})) + S_W'($signed(sf.p));
    ys    = yq - S_W'($signed(sf.p));
    fxo_c = sat_out((xs + S_W'(HALF_LSB)) >>> Q_SH);
    fyo_c = sat_out((ys + S_W'(HALF_LSB)) >>> Q_SH);
    absv  = fxo_c[OUT_W-1] ? OUT_W'(-fxo_c) : OUT_W'(fxo_c);
    mag_nxt = {absv, {FRAC_BITS{1'b0}}};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mag_r <= mag_nxt;
    end
  end

  // ---- divider chain ----
  always_comb begin
    dv_d[0].rem = '0;
    dv_d[0].num = mag_r;
    dv_d[0].q   = '0;
  end

  for (genvar j = 0; j < Q_W; j++) begin : g_div
    vfp_div_cell u_div (
      .clk(clk), .en(en), .divisor(div_r), .d_i(dv_d[j]), .d_o(dv_d[j+1])
    );
  end

  localparam logic [Q_W-1:0] Q_LIM = Q_W'(1) << (OUT_W - 1);

  logic [OUT_W-1:0] qc;

  always_comb begin
    qc = (dv_d[Q_W].q > Q_LIM) ? OUT_W'(Q_LIM) : OUT_W'(dv_d[Q_W].q);
    if (div_r == '0) sens_nxt = '0;
    else if (side_r[ST_END-1].neg) sens_nxt = -$signed(qc);
    else if (qc == OUT_W'(Q_LIM)) sens_nxt = OUT_W'(OUT_MAX);
    else sens_nxt = $signed(qc);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sens_r <= sens_nxt;
    end
  end

  // ---- sideband line ----
  logic [FOV_W-1:0] fx_in;
  logic [FOV_W-1:0] fx_c;

  always_comb begin
    fx_in = in_tdata[23:0];
    fx_c  = (fx_in > FOV_MAX) ? FOV_MAX : fx_in;
    side_nxt[0]         = '0;
    side_nxt[0].fx      = fx_c;
    side_nxt[0].w       = in_tdata[35:24];
    side_nxt[0].h       = in_tdata[47:36];
    side_nxt[0].hit1    = in_tuser[0];
    side_nxt[0].hit2    = in_tuser[1];
    side_nxt[0].fy_zero = (fx_c == '0) || (in_tdata[47:36] == '0);
    side_nxt[0].fy_full = (fx_c == FOV_MAX) || (in_tdata[35:24] == '0);
    for (int k = 1; k <= ST_END; k++) begin
      side_nxt[k] = side_r[k-1];
      if (k == ST_MUL) begin
        side_nxt[k].p      = p_val;
        side_nxt[k].base90 = swap;
      end
      if (k == ST_FIN) begin
        side_nxt[k].fxo = fxo_c;
        side_nxt[k].fyo = fyo_c;
        side_nxt[k].neg = fxo_c[OUT_W-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k <= ST_END; k++) begin
        side_r[k] <= side_nxt[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[ST_END-1:0], in_tvalid};
    end
  end

  // ---- output register and skid stage ----
  assign res_data = {5'd0, sens_r, side_r[ST_END].fyo, side_r[ST_END].fxo};
  assign res_user = {side_r[ST_END].hit1, side_r[ST_END].hit2};

  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    out_user_nxt   = out_user_r;
    skid_valid_nxt = skid_valid_r;
    skid_data_nxt  = skid_data_r;
    skid_user_nxt  = skid_user_r;
    if (skid_valid_r) begin
      if (out_tready) begin
        out_valid_nxt  = 1'b1;
        out_data_nxt   = skid_data_r;
        out_user_nxt   = skid_user_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (!out_valid_r || out_tready) begin
      out_valid_nxt = vld_r[ST_END];
      out_data_nxt  = res_data;
      out_user_nxt  = res_user;
    end else if (vld_r[ST_END]) begin
      skid_valid_nxt = 1'b1;
      skid_data_nxt  = res_data;
      skid_user_nxt  = res_user;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    out_user_r  <= out_user_nxt;
    skid_data_r <= skid_data_nxt;
    skid_user_r <= skid_user_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule

`default_nettype wire

[tb/sv/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the FOV projection unit: a queue-fed stream driver
// with random gaps, a stalling result sink, an in-bench fixed-point predictor
// of the FOV/pulse/sensitivity maths, and several divisor settings.
// ----------------------------------------------------------------------------
module tb;
  import vfp_pkg::*;

  typedef struct {
    logic [23:0] fov;
    logic [11:0] w;
    logic [11:0] h;
    logic [31:0] t;
    logic        hit1;
    logic        hit2;
  } view_item_t;

  typedef struct {
    logic [24:0] fxo;
    logic [24:0] fyo;
    logic [24:0] sens;
    logic        draw;
    logic        hit;
  } fov_result_t;

  localparam longint ONE_DEG = 64'sd1 <<< 30;
  localparam int     WDOG_LIMIT = 5000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic [79:0] in_tdata = '0;
  logic [1:0]  in_tuser = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [79:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [2:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  view_item_t  pending_views[$];
  fov_result_t expected_fovs[$];
  logic [23:0] fov_divisor = 24'd5242880;
  int          errors = 0;
  int          n_in = 0;
  bit          in_took = 0, out_took = 0;
  int          send_gap = 0, recv_gap = 0, hold_left = 0, wdog = 0;
  bit          send_burst = 0, recv_burst = 0, hold_done = 0;

  view_fov_projection_unit dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // arctan(2^-i) in Q30 degrees
  function automatic longint atan_q30(int i);
    longint unsigned p, sum, t, k;
    int sh;
    if (i == 0) return 45 * ONE_DEG;
    p = 64'd1 << (62 - i);
    sh = 2 * i;
    sum = 0;
    k = 0;
    while (p != 0) begin
      t = p / (2 * k + 1);
      if (k[0]) sum = sum - t;
      else sum = sum + t;
      p = p >> sh;
      k++;
    end
    return longint'((((sum >> 28) * 64'd961263669) + (64'd1 << 27)) >> 28);
  endfunction

  function automatic void rotate_by(longint z, inout longint x, inout longint y);
    longint dx, dy;
    for (int i = 0; i < CORDIC_STAGES; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= atan_q30(i);
      end else begin
        x += dx; y -= dy; z += atan_q30(i);
      end
    end
  endfunction

  function automatic longint angle_of(longint x, longint y);
    longint z, dx, dy;
    z = 0;
    for (int i = 0; i < CORDIC_STAGES; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x += dx; y -= dy; z += atan_q30(i);
      end else begin
        x -= dx; y += dy; z -= atan_q30(i);
      end
    end
    return z;
  endfunction

  function automatic longint sat25(longint v);
    if (v > 16777215) return 16777215;
    if (v < -16777216) return -16777216;
    return v;
  endfunction

  function automatic longint q30_to_fov(longint v);
    return (v + (64'sd1 <<< 13)) >>> 14;
  endfunction

  function automatic fov_result_t project_view(view_item_t it, logic [23:0] div);
    fov_result_t r;
    longint fx, w, h, yq, p, fxo, fyo, sens, cx, cy, xx, yy, base, tt, ph, ang, sx, sy;
    longint unsigned mag, q;
    fx = it.fov;
    w = it.w;
    h = it.h;
    p = 0;
    sens = 0;
    if (fx > 180 * 65536) fx = 180 * 65536;
    if (fx == 0 || h == 0) yq = 0;
    else if (fx == 180 * 65536 || w == 0) yq = 180 * ONE_DEG;
    else begin
      cx = ONE_DEG;
      cy = 0;
      base = 0;
      rotate_by((fx <<< 14) / 2, cx, cy);
      xx = w * cx;
      yy = h * cy;
      if (xx < 0) begin
        tt = xx; xx = yy; yy = -tt; base = 90 * ONE_DEG;
      end
      yq = 2 * (base + angle_of(xx, yy));
      if (yq < 0) yq = 0;
      if (yq > 180 * ONE_DEG) yq = 180 * ONE_DEG;
    end
    if (it.hit1) begin
      tt = longint'(signed'(it.t));
      ph = tt % 2500;
      if (ph < 0) ph += 2500;
      ang = (((ph * 360) <<< 30) + 1250) / 2500;
      if (ang > 90 * ONE_DEG && ang <= 270 * ONE_DEG) ang = 180 * ONE_DEG - ang;
      else if (ang > 270 * ONE_DEG) ang -= 360 * ONE_DEG;
      sx = 64'sd652032874;
      sy = 0;
      rotate_by(ang, sx, sy);
      p = sy;
    end
    fxo = sat25(q30_to_fov((fx <<< 14) + p));
    fyo = sat25(q30_to_fov(yq - p));
    if (div != 0) begin
      mag = longint'(fxo < 0 ? -fxo : fxo) << 16;
      q = mag / div;
      if (q > 16777216) q = 16777216;
      sens = sat25(fxo < 0 ? -longint'(q) : longint'(q));
    end
    r.fxo = fxo[24:0];
    r.fyo = fyo[24:0];
    r.sens = sens[24:0];
    r.draw = it.hit2;
    r.hit = it.hit1;
    return r;
  endfunction

  // stream driver
  always @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      expected_fovs.push_back(project_view(view_item_t'{in_tdata[23:0], in_tdata[35:24],
          in_tdata[47:36], in_tdata[79:48], in_tuser[0], in_tuser[1]}, fov_divisor));
      n_in++;
      in_took = 1;
    end
  end

  always @(negedge clk) begin
    logic nv;
    view_item_t it;
    nv = in_tvalid;
    if (in_took) begin
      nv = 0;
      in_took = 0;
      if ($urandom_range(0, 49) == 0) send_burst = !send_burst;
      send_gap = send_burst ? 0 : $urandom_range(0, 9);
    end
    if (!nv && rst_n) begin
      if (send_gap > 0) send_gap--;
      else if (pending_views.size() > 0) begin
        it = pending_views.pop_front();
        in_tdata <= {it.t, it.h, it.w, it.fov};
        in_tuser <= {it.hit2, it.hit1};
        nv = 1;
      end
    end
    in_tvalid <= nv;
  end

  // result sink
  always @(posedge clk) begin
    fov_result_t e;
    if (out_tvalid && out_tready) begin
      out_took = 1;
      if (expected_fovs.size() == 0) begin
        $display("%0t: unexpected result %h", $realtime, out_tdata);
        errors++;
      end else begin
        e = expected_fovs.pop_front();
        if (out_tdata[24:0] !== e.fxo) begin
          $display("%0t: fov_x_out exp %h got %h", $realtime, e.fxo, out_tdata[24:0]);
          errors++;
        end
        if (out_tdata[49:25] !== e.fyo) begin
          $display("%0t: fov_y_out exp %h got %h", $realtime, e.fyo, out_tdata[49:25]);
          errors++;
        end
        if (out_tdata[74:50] !== e.sens) begin
          $display("%0t: sensitivity exp %h got %h", $realtime, e.sens, out_tdata[74:50]);
          errors++;
        end
        if (out_tuser !== {e.hit, e.draw}) begin
          $display("%0t: tuser exp %b got %b", $realtime, {e.hit, e.draw}, out_tuser);
          errors++;
        end
      end
    end
  end

  always @(negedge clk) begin
    if (out_took) begin
      out_took = 0;
      if ($urandom_range(0, 49) == 0) recv_burst = !recv_burst;
      recv_gap = recv_burst ? 0 : $urandom_range(0, 9);
    end
    // one long hold-off so the pipeline backs up into the input
    if (!hold_done && n_in >= 200) begin
      hold_done = 1;
      hold_left = 400;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else if (recv_gap > 0) begin
      recv_gap--;
      out_tready <= 1'b0;
    end else out_tready <= rst_n;
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || !rst_n) wdog <= 0;
    else if (wdog >= WDOG_LIMIT) begin
      $display("status: fail");
      $finish;
    end else wdog <= wdog + 1;
  end

  task automatic write_divisor(logic [23:0] v);
    @(negedge clk);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= 3'(REG_SENS_DIV) << 2;
    cfg_pwdata <= {8'd0, v};
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    fov_divisor = v;
  endtask

  task automatic add_view(logic [23:0] fov, logic [11:0] w, logic [11:0] h,
                          logic [31:0] t, logic h1, logic h2);
    pending_views.push_back(view_item_t'{fov, w, h, t, h1, h2});
  endtask

  task automatic add_random_view();
    logic [23:0] fov;
    logic [11:0] w, h;
    fov = ($urandom_range(0, 9) == 0) ? 24'($urandom) : 24'($urandom_range(0, 11796480));
    w = ($urandom_range(0, 19) == 0) ? 12'($urandom) : 12'($urandom_range(1, 4095));
    h = ($urandom_range(0, 19) == 0) ? 12'($urandom) : 12'($urandom_range(1, 4095));
    add_view(fov, w, h, $urandom, 1'($urandom), 1'($urandom));
  endtask

  task automatic drain();
    wait (pending_views.size() == 0 && !in_tvalid && expected_fovs.size() == 0);
    repeat (100) @(posedge clk);
  endtask

  initial begin
    logic [23:0] divs[5];
    divs = '{24'd65536, 24'd11796480, 24'hFFFFFF, 24'd0, 24'd5898240};
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    // directed: FOV and size extremes, saturation, pulse phases, flag combos
    add_view(24'd0, 12'd640, 12'd480, 32'd0, 1'b0, 1'b0);
    add_view(24'd11796480, 12'd640, 12'd480, 32'd0, 1'b0, 1'b1);
    add_view(24'hFFFFFF, 12'd640, 12'd480, 32'd625, 1'b1, 1'b0);
    add_view(24'd5898240, 12'd0, 12'd480, 32'd0, 1'b0, 1'b0);
    add_view(24'd5898240, 12'd640, 12'd0, 32'd0, 1'b0, 1'b0);
    add_view(24'd0, 12'd0, 12'd0, 32'd0, 1'b1, 1'b1);
    add_view(24'd1, 12'd4095, 12'd1, 32'd1875, 1'b1, 1'b1);
    add_view(24'd11796479, 12'd1, 12'd4095, 32'd625, 1'b1, 1'b0);
    add_view(24'd5898240, 12'd4095, 12'd4095, 32'h80000000, 1'b1, 1'b1);
    add_view(24'd5898240, 12'd4095, 12'd4095, 32'h7FFFFFFF, 1'b1, 1'b0);
    add_view(24'd6553600, 12'd1920, 12'd1080, 32'hFFFFFFFF, 1'b1, 1'b1);
    add_view(24'd6553600, 12'd1920, 12'd1080, 32'd1250, 1'b1, 1'b0);
    add_view(24'd6553600, 12'd1920, 12'd1080, 32'd2499, 1'b1, 1'b0);
    add_view(24'd6553600, 12'd1920, 12'd1080, 32'd2500, 1'b1, 1'b1);
    add_view(24'd0, 12'd640, 12'd480, 32'd1875, 1'b1, 1'b0);
    add_view(24'd11796480, 12'd640, 12'd480, 32'd625, 1'b1, 1'b0);
    add_view(24'd100, 12'd1, 12'd4095, 32'hFFFFF63C, 1'b1, 1'b1);
    add_view(24'hAAAAAA, 12'hAAA, 12'h555, 32'h55555555, 1'b0, 1'b1);
    add_view(24'h555555, 12'h555, 12'hAAA, 32'hAAAAAAAA, 1'b1, 1'b0);
    for (int i = 0; i < 130; i++) add_random_view();
    drain();
    foreach (divs[d]) begin
      write_divisor(divs[d]);
      for (int i = 0; i < 144; i++) add_random_view();
      drain();
    end
    if (errors == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule
